// ----- design/tms_pkg.sv -----
// ---------------------------------------------------------------------------
// tms_pkg
// Shared widths, limits and controller/datapath interface types for the
// tactile matrix statistics block.
// ---------------------------------------------------------------------------
`default_nettype none

package tms_pkg;

  localparam int VALUE_W       = 12;
  localparam int COUNT_W       = 9;
  localparam int IDX_W         = 3;
  localparam int ACT_W         = 4;
  localparam int SUM_W         = 21;
  localparam int MEAN_W        = 20;
  localparam int MEAN_SUM_W    = 23;
  localparam int FRACTION_BITS = 8;

  localparam int MAX_CELLS     = 256;
  localparam int MAX_MATRICES  = 8;

  localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = {VALUE_W{1'b1}};

  // Shared divider operand sizes.
  localparam int DIV_DIVIDEND_W = SUM_W + FRACTION_BITS;
  localparam int DIV_DIVISOR_W  = COUNT_W;
  localparam int DIV_STEPS_W    = $clog2(DIV_DIVIDEND_W);

  localparam logic KIND_MATRIX = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  typedef struct packed {
    logic accept;     // a cell transfer is taken this cycle
    logic mat_start;  // start the matrix mean division
    logic mat_load;   // load the matrix record and close the matrix
    logic frm_start;  // start the frame mean division
    logic frm_load;   // load the frame record and close the frame
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;   // divider finished this cycle
    logic out_free;   // output register can take a record this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/tms_div.sv -----
// ---------------------------------------------------------------------------
// tms_div
// Restoring divider, one quotient bit per cycle, shared by the matrix and
// frame mean computations.
// ---------------------------------------------------------------------------
`default_nettype none

module tms_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [tms_pkg::DIV_DIVIDEND_W-1:0] dividend,
  input  wire logic [tms_pkg::DIV_DIVISOR_W-1:0]  divisor,
  output logic      [tms_pkg::DIV_DIVIDEND_W-1:0] quotient,
  output logic                                    done
);
  import tms_pkg::*;

  logic                        busy;
  logic [DIV_STEPS_W-1:0]      steps;
  logic [DIV_DIVISOR_W-1:0]    dsr;
  logic [DIV_DIVISOR_W-1:0]    rem;
  logic [DIV_DIVISOR_W:0]      rem_shift;
  logic [DIV_DIVISOR_W:0]      rem_diff;
  logic                        q_bit;
  logic [DIV_DIVISOR_W-1:0]    rem_next;

  always_comb begin
    rem_shift = {rem, quotient[DIV_DIVIDEND_W-1]};
    rem_diff  = rem_shift - {1'b0, dsr};
    q_bit     = rem_shift >= {1'b0, dsr};
    rem_next  = q_bit ? rem_diff[DIV_DIVISOR_W-1:0] : rem_shift[DIV_DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == DIV_STEPS_W'(DIV_DIVIDEND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The quotient shifts in over the dividend bits as they are consumed.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      steps    <= '0;
    end else if (busy) begin
      quotient <= {quotient[DIV_DIVIDEND_W-2:0], q_bit};
      rem      <= rem_next;
      steps    <= steps + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/tms_datapath.sv -----
// ---------------------------------------------------------------------------
// tms_datapath
// Matrix and frame accumulators, the shared mean divider and the output
// record register.
// ---------------------------------------------------------------------------
`default_nettype none

module tms_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tms_pkg::ctrl_cmd_t            cmd,
  output tms_pkg::dp_status_t                status,
  input  wire logic [tms_pkg::VALUE_W-1:0]   cell_value,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               record_kind,
  output logic      [tms_pkg::IDX_W-1:0]     matrix_index,
  output logic      [tms_pkg::COUNT_W-1:0]   active_count,
  output logic      [tms_pkg::MEAN_W-1:0]    mean_value,
  output logic      [tms_pkg::VALUE_W-1:0]   min_value,
  output logic      [tms_pkg::VALUE_W-1:0]   max_value,
  output logic                               last_of_frame
);
  import tms_pkg::*;

  logic [COUNT_W-1:0]        cell_count;
  logic [SUM_W-1:0]          cell_sum;
  logic [VALUE_W-1:0]        cell_min;
  logic [VALUE_W-1:0]        cell_max;
  logic [IDX_W-1:0]          matrix_counter;
  logic [MEAN_SUM_W-1:0]     mean_sum;
  logic [ACT_W-1:0]          active_matrices;
  logic [VALUE_W-1:0]        frame_min;
  logic [VALUE_W-1:0]        frame_max;

  logic                      div_start;
  logic [DIV_DIVIDEND_W-1:0] div_dividend;
  logic [DIV_DIVISOR_W-1:0]  div_divisor;
  logic [DIV_DIVIDEND_W-1:0] div_quotient;
  logic                      div_done;

  logic                      cell_active;
  logic                      mat_active;
  logic                      frm_active;
  logic [MEAN_W-1:0]         mean;

  assign cell_active = cell_value != '0;
  assign mat_active  = cell_count != '0;
  assign frm_active  = active_matrices != '0;
  assign mean        = div_quotient[MEAN_W-1:0];

  assign div_start = cmd.mat_start | cmd.frm_start;

  always_comb begin
    if (cmd.frm_start) begin
      div_dividend = DIV_DIVIDEND_W'(mean_sum);
      div_divisor  = DIV_DIVISOR_W'(active_matrices);
    end else begin
      div_dividend = {cell_sum, {FRACTION_BITS{1'b0}}};
      div_divisor  = cell_count;
    end
  end

  tms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  // Current matrix accumulators.
  always_ff @(posedge clk) begin
    if (rst || cmd.mat_load) begin
      cell_count <= '0;
      cell_sum   <= '0;
      cell_min   <= VALUE_ALL_ONES;
      cell_max   <= '0;
    end else if (cmd.accept && cell_active) begin
      // Past the cell limit the mean keeps the first counted cells only.
      if (cell_count < COUNT_W'(MAX_CELLS)) begin
        cell_count <= cell_count + 1'b1;
        cell_sum   <= cell_sum + SUM_W'(cell_value);
      end
      if (cell_value < cell_min) cell_min <= cell_value;
      if (cell_value > cell_max) cell_max <= cell_value;
    end
  end

  // Current frame accumulators.
  always_ff @(posedge clk) begin
    if (rst || cmd.frm_load) begin
      matrix_counter  <= '0;
      mean_sum        <= '0;
      active_matrices <= '0;
      frame_min       <= VALUE_ALL_ONES;
      frame_max       <= '0;
    end else if (cmd.mat_load) begin
      if (matrix_counter < IDX_W'(MAX_MATRICES - 1)) begin
        matrix_counter <= matrix_counter + 1'b1;
      end
      if (mat_active) begin
        if (active_matrices < ACT_W'(MAX_MATRICES)) begin
          active_matrices <= active_matrices + 1'b1;
          mean_sum        <= mean_sum + MEAN_SUM_W'(mean);
        end
        if (cell_min < frame_min) frame_min <= cell_min;
        if (cell_max > frame_max) frame_max <= cell_max;
      end
    end
  end

  // Output record register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.mat_load || cmd.frm_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mat_load) begin
      record_kind   <= KIND_MATRIX;
      matrix_index  <= matrix_counter;
      active_count  <= cell_count;
      mean_value    <= mat_active ? mean : '0;
      min_value     <= mat_active ? cell_min : '0;
      max_value     <= mat_active ? cell_max : '0;
      last_of_frame <= 1'b0;
    end else if (cmd.frm_load) begin
      record_kind   <= KIND_FRAME;
      matrix_index  <= '0;
      active_count  <= COUNT_W'(active_matrices);
      mean_value    <= frm_active ? mean : '0;
      min_value     <= frm_active ? frame_min : '0;
      max_value     <= frm_active ? frame_max : '0;
      last_of_frame <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/tms_ctrl.sv -----
// ---------------------------------------------------------------------------
// tms_ctrl
// Sequencer: takes cells, and at matrix and frame ends runs the mean
// division and hands the record to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tms_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_eom,
  input  wire logic                 in_eof,
  output logic                      in_ready,
  input  wire tms_pkg::dp_status_t  status,
  output tms_pkg::ctrl_cmd_t        cmd
);
  import tms_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MSTART = 3'd1;
  localparam logic [2:0] ST_MDIV   = 3'd2;
  localparam logic [2:0] ST_MLOAD  = 3'd3;
  localparam logic [2:0] ST_FSTART = 3'd4;
  localparam logic [2:0] ST_FDIV   = 3'd5;
  localparam logic [2:0] ST_FLOAD  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       eof_pending;
  logic       end_of_matrix;

  // A frame end also closes the matrix.
  assign end_of_matrix = in_eom || in_eof;
  assign in_ready      = state == ST_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.accept    = in_valid && in_ready;
    cmd.mat_start = state == ST_MSTART;
    cmd.frm_start = state == ST_FSTART;
    cmd.mat_load  = state == ST_MLOAD && status.out_free;
    cmd.frm_load  = state == ST_FLOAD && status.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept && end_of_matrix) state_next = ST_MSTART;
      end
      ST_MSTART: state_next = ST_MDIV;
      ST_MDIV: begin
        if (status.div_done) state_next = ST_MLOAD;
      end
      ST_MLOAD: begin
        if (status.out_free) state_next = eof_pending ? ST_FSTART : ST_IDLE;
      end
      ST_FSTART: state_next = ST_FDIV;
      ST_FDIV: begin
        if (status.div_done) state_next = ST_FLOAD;
      end
      ST_FLOAD: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      eof_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) eof_pending <= in_eof;
    end
  end

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mat_start, cmd.mat_load, cmd.frm_start, cmd.frm_load}))
    else $error("more than one sequencer command at once");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.mat_load || cmd.frm_load) |-> status.out_free)
    else $error("record loaded over an untaken record");

  a_frame_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd.mat_load && eof_pending) |=> state == ST_FSTART)
    else $error("frame record not started after last matrix");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.mat_start |-> !cmd.accept)
    else $error("cell taken while a matrix is closing");
`endif

endmodule

`default_nettype wire

// ----- design/tactile_matrix_statistics.sv -----
// ---------------------------------------------------------------------------
// tactile_matrix_statistics
// Active-cell count, mean, minimum and maximum per matrix and per frame of
// a tactile sensor cell stream.
// ---------------------------------------------------------------------------
// Cells are taken one per cycle while a matrix is in progress. A transfer
// with tlast (end of matrix) or tuser (end of frame) set stops input while
// the matrix mean is divided on a one-bit-per-cycle restoring divider: the
// matrix record is then loaded into the output register and input resumes
// right after the load. At a frame end the same divider then computes the
// frame mean before the frame record is loaded and input resumes. A pending
// record waits in the output register while the next cells are taken; a new
// record is loaded only when the previous one has been transferred out, so a
// stalled receiver delays the load and the resumption of input.
// ---------------------------------------------------------------------------
`default_nettype none

module tactile_matrix_statistics (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [11:0] cell_value, [15:12] zero
  input  wire logic        s_axis_tlast,   // end_of_matrix
  input  wire logic        s_axis_tuser,   // end_of_frame
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [55:0] m_axis_tdata,   // [2:0] matrix_index, [11:3] active_count,
                                           // [31:12] mean_value, [43:32] min_value,
                                           // [55:44] max_value
  output logic             m_axis_tlast,   // last_of_frame
  output logic             m_axis_tuser    // record_kind
);
  import tms_pkg::*;

  ctrl_cmd_t           cmd;
  dp_status_t          status;
  logic [IDX_W-1:0]    matrix_index;
  logic [COUNT_W-1:0]  active_count;
  logic [MEAN_W-1:0]   mean_value;
  logic [VALUE_W-1:0]  min_value;
  logic [VALUE_W-1:0]  max_value;

  tms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_eom   (s_axis_tlast),
    .in_eof   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tms_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cell_value    (s_axis_tdata[VALUE_W-1:0]),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .record_kind   (m_axis_tuser),
    .matrix_index  (matrix_index),
    .active_count  (active_count),
    .mean_value    (mean_value),
    .min_value     (min_value),
    .max_value     (max_value),
    .last_of_frame (m_axis_tlast)
  );

  assign m_axis_tdata = {max_value, min_value, mean_value, active_count, matrix_index};

endmodule

`default_nettype wire

// ----- tb/tactile_matrix_statistics_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tactile_matrix_statistics_test
// Streams tactile cells into the statistics block and checks every matrix
// and frame record against a cycle-free prediction of the block.
// ---------------------------------------------------------------------------
// A short directed run covers the value extremes, empty matrices and
// frames, and a frame end without a matrix end. Random frames follow: mostly
// well-formed frames with random sizes and fill levels, some oversized
// matrices and frames that saturate the counters, and some noise transfers.
// The run goes through phases without idling, with an idle sender, with a
// stalling receiver, and with both.
// ---------------------------------------------------------------------------

module tactile_matrix_statistics_test;
  import tms_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               eom;
    logic               eof;
  } cell_t;

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] cnt;
    logic [MEAN_W-1:0]  mean;
    logic [VALUE_W-1:0] mn;
    logic [VALUE_W-1:0] mx;
    logic               last;
  } stats_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [11:0] cell_value, [15:12] zero
  logic        s_axis_tlast = 1'b0;  // end_of_matrix
  logic        s_axis_tuser = 1'b0;  // end_of_frame
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;  // [2:0] matrix_index, [11:3] active_count,
                              // [31:12] mean_value, [43:32] min_value,
                              // [55:44] max_value
  logic        m_axis_tlast;  // last_of_frame
  logic        m_axis_tuser;  // record_kind

  cell_t      cell_queue[$];
  stats_rec_t stats_due[$];
  int         cells_queued = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         error_count = 0;
  int         cycle_count = 0;

  // Predicted block state: the matrix being collected and the frame so far.
  logic [COUNT_W-1:0]    acc_count = '0;
  logic [SUM_W-1:0]      acc_sum = '0;
  logic [VALUE_W-1:0]    acc_min = VALUE_ALL_ONES;
  logic [VALUE_W-1:0]    acc_max = '0;
  logic [IDX_W-1:0]      mat_index = '0;
  logic [MEAN_SUM_W-1:0] frm_mean_sum = '0;
  logic [ACT_W-1:0]      frm_active = '0;
  logic [VALUE_W-1:0]    frm_min = VALUE_ALL_ONES;
  logic [VALUE_W-1:0]    frm_max = '0;

  tactile_matrix_statistics u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Updates the predicted state for one accepted cell and queues the records
  // that the cell closes.
  task automatic account_cell(input logic [VALUE_W-1:0] v, input logic eom_in,
                              input logic eof_in);
    logic [DIV_DIVIDEND_W-1:0] dividend;
    logic [MEAN_W-1:0]         mean;
    stats_rec_t                rec;
    if (v != '0) begin
      // Past the cell limit only the extremes keep moving.
      if (acc_count < COUNT_W'(MAX_CELLS)) begin
        acc_count = acc_count + 1'b1;
        acc_sum = acc_sum + SUM_W'(v);
      end
      if (v < acc_min) acc_min = v;
      if (v > acc_max) acc_max = v;
    end
    if (eom_in || eof_in) begin
      rec = '0;
      rec.kind = KIND_MATRIX;
      rec.idx = mat_index;
      if (acc_count != '0) begin
        dividend = DIV_DIVIDEND_W'(acc_sum) << FRACTION_BITS;
        mean = MEAN_W'(dividend / DIV_DIVIDEND_W'(acc_count));
        rec.cnt = acc_count;
        rec.mean = mean;
        rec.mn = acc_min;
        rec.mx = acc_max;
        if (frm_active < ACT_W'(MAX_MATRICES)) begin
          frm_active = frm_active + 1'b1;
          frm_mean_sum = frm_mean_sum + MEAN_SUM_W'(mean);
        end
        if (acc_min < frm_min) frm_min = acc_min;
        if (acc_max > frm_max) frm_max = acc_max;
      end
      stats_due.insert(stats_due.size(), rec);
      acc_count = '0;
      acc_sum = '0;
      acc_min = VALUE_ALL_ONES;
      acc_max = '0;
      if (mat_index < IDX_W'(MAX_MATRICES - 1)) mat_index = mat_index + 1'b1;
      if (eof_in) begin
        rec = '0;
        rec.kind = KIND_FRAME;
        rec.last = 1'b1;
        if (frm_active != '0) begin
          rec.cnt = COUNT_W'(frm_active);
          rec.mean = MEAN_W'(frm_mean_sum / MEAN_SUM_W'(frm_active));
          rec.mn = frm_min;
          rec.mx = frm_max;
        end
        stats_due.insert(stats_due.size(), rec);
        mat_index = '0;
        frm_mean_sum = '0;
        frm_active = '0;
        frm_min = VALUE_ALL_ONES;
        frm_max = '0;
      end
    end
  endtask

  task automatic push_cell(input logic [VALUE_W-1:0] v, input logic eom, input logic eof);
    cell_t c;
    c.value = v;
    c.eom = eom;
    c.eof = eof;
    cell_queue.insert(cell_queue.size(), c);
    cells_queued++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(input int active_pct);
    int r;
    if ($urandom_range(0, 99) >= active_pct) return '0;
    r = $urandom_range(0, 9);
    if (r == 0) return VALUE_ALL_ONES;
    if (r == 1) return VALUE_W'(1);
    return VALUE_W'($urandom_range(1, 4095));
  endfunction

  task automatic add_frame();
    int  n_mat;
    int  n_cells;
    int  pct;
    int  r;
    bit  last_mat;
    bit  close_eom;
    r = $urandom_range(0, 9);
    if (r < 7) n_mat = $urandom_range(1, 4);
    else if (r < 9) n_mat = $urandom_range(5, 8);
    else n_mat = $urandom_range(9, 11);
    for (int m = 0; m < n_mat; m++) begin
      last_mat = (m == n_mat - 1);
      n_cells = ($urandom_range(0, 149) == 0) ? $urandom_range(257, 262)
                                               : $urandom_range(1, 6);
      r = $urandom_range(0, 9);
      pct = (r == 0) ? 0 : (r < 4) ? 50 : 95;
      // The frame may end with or without the matrix mark.
      close_eom = last_mat ? bit'($urandom_range(0, 1)) : 1'b1;
      for (int i = 0; i < n_cells; i++)
        push_cell(pick_value(pct), (i == n_cells - 1) && close_eom,
                  (i == n_cells - 1) && last_mat);
    end
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++)
      push_cell(pick_value(70), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_cells);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = cells_queued + n_cells;
    while (cells_queued < target) begin
      if ($urandom_range(0, 99) < 85) add_frame();
      else add_noise();
    end
    while (cell_queue.size() != 0 || s_axis_tvalid) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_cells
    cell_t c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        account_cell(s_axis_tdata[VALUE_W-1:0], s_axis_tlast, s_axis_tuser);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cell_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          c = cell_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= 16'(c.value);
          s_axis_tlast <= c.eom;
          s_axis_tuser <= c.eof;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_records
    stats_rec_t got;
    stats_rec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.idx = m_axis_tdata[2:0];
      got.cnt = m_axis_tdata[11:3];
      got.mean = m_axis_tdata[31:12];
      got.mn = m_axis_tdata[43:32];
      got.mx = m_axis_tdata[55:44];
      got.last = m_axis_tlast;
      if (stats_due.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected record: kind=%0d idx=%0d cnt=%0d ",
                   got.kind, got.idx, got.cnt,
                   "mean=%05h min=%0d max=%0d last=%0d",
                   got.mean, got.mn, got.mx, got.last);
      end else begin
        want = stats_due.pop_front();
        if (got.kind !== want.kind || got.idx !== want.idx || got.cnt !== want.cnt ||
            got.mean !== want.mean || got.mn !== want.mn || got.mx !== want.mx ||
            got.last !== want.last) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("record mismatch: expected kind=%0d idx=%0d cnt=%0d ",
                     want.kind, want.idx, want.cnt,
                     "mean=%05h min=%0d max=%0d last=%0d, ",
                     want.mean, want.mn, want.mx, want.last,
                     "got kind=%0d idx=%0d cnt=%0d ",
                     got.kind, got.idx, got.cnt,
                     "mean=%05h min=%0d max=%0d last=%0d",
                     got.mean, got.mn, got.mx, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tactile_matrix_statistics_test failed");
      $finish;
    end
  end

  initial begin
    // Value extremes within one matrix.
    push_cell(VALUE_ALL_ONES, 1'b0, 1'b0);
    push_cell(VALUE_W'(1), 1'b0, 1'b0);
    push_cell('0, 1'b0, 1'b0);
    push_cell(VALUE_W'(2048), 1'b1, 1'b0);
    // A matrix with no active cell.
    push_cell('0, 1'b0, 1'b0);
    push_cell('0, 1'b1, 1'b0);
    // A single full-scale cell closes matrix and frame.
    push_cell(VALUE_ALL_ONES, 1'b1, 1'b1);
    // Frame end without the matrix mark.
    push_cell(VALUE_W'(1), 1'b0, 1'b0);
    push_cell('0, 1'b0, 1'b1);
    // A frame with nothing active at all.
    push_cell('0, 1'b1, 1'b1);
    // Alternating bit patterns.
    push_cell(VALUE_W'(12'hAAA), 1'b0, 1'b0);
    push_cell(VALUE_W'(12'h555), 1'b1, 1'b0);
    push_cell(VALUE_W'(12'h800), 1'b1, 1'b1);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // One matrix well past the cell limit; the late cells move only the
    // extremes.
    for (int i = 0; i < MAX_CELLS; i++)
      push_cell(VALUE_W'($urandom_range(2, 4094)), 1'b0, 1'b0);
    push_cell(VALUE_W'(1), 1'b0, 1'b0);
    push_cell(VALUE_ALL_ONES, 1'b0, 1'b0);
    push_cell('0, 1'b0, 1'b0);
    push_cell(VALUE_W'($urandom_range(1, 4095)), 1'b1, 1'b0);
    run_phase(0, 0, 265);
    run_phase(66, 0, 265);
    run_phase(0, 66, 265);
    run_phase(25, 25, 265);
    while (stats_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (error_count == 0 && stats_due.size() == 0) begin
      $display("tactile_matrix_statistics_test passed");
    end else begin
      $display("tactile_matrix_statistics_test failed");
    end
    $finish;
  end

endmodule
